[hdl/ppi_pkg.sv]
// Package for the polyline position interpolator: widths, sequencer states
// and the arctangent table. No dependencies.
package ppi_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int IDX_W        = $clog2(MAX_POINTS);
    localparam int PC_W         = 7;
    localparam int COORD_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int LEN_W        = COORD_W + 1;
    localparam int SQ_W         = 2 * COORD_W + 2;
    localparam int TOT_W        = LEN_W + IDX_W;
    localparam int POS_W        = 32;
    localparam int MUL_W        = DIFF_W + 1;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int NUM_W        = PROD_W + 1;
    localparam int DIV_W        = 44;
    localparam int DCNT_W       = $clog2(DIV_W);
    localparam int XPOS_W       = 24;
    localparam int DEG_W        = 9;
    localparam int CORDIC_STEPS = 20;
    localparam int CI_W         = $clog2(CORDIC_STEPS);
    localparam int CXY_W        = 28;
    localparam int Z_W          = 24;
    localparam int IN_DATA_W    = 72;
    localparam int OUT_DATA_W   = 80;

    typedef enum logic [4:0] {
        ST_IDLE, ST_L_RD, ST_L_MX, ST_L_MY, ST_L_SQ, ST_L_WAIT, ST_CHK,
        ST_MOD, ST_MOD_WAIT, ST_W_RD, ST_W_CMP, ST_V_RD, ST_V_LD,
        ST_X_M1, ST_X_M2, ST_X_DIV, ST_X_WAIT, ST_Y_M1, ST_Y_M2, ST_Y_DIV,
        ST_Y_WAIT, ST_HD, ST_HD_WAIT, ST_DONE
    } t_state;

    // atan(2^-i) in degrees, scaled by 2^16
    function automatic logic [Z_W-1:0] atan_deg(input logic [CI_W-1:0] i);
        logic [Z_W-1:0] v;
        unique case (i)
            5'd0:  v = 24'd2949120;
            5'd1:  v = 24'd1740967;
            5'd2:  v = 24'd919879;
            5'd3:  v = 24'd466945;
            5'd4:  v = 24'd234379;
            5'd5:  v = 24'd117304;
            5'd6:  v = 24'd58666;
            5'd7:  v = 24'd29335;
            5'd8:  v = 24'd14668;
            5'd9:  v = 24'd7334;
            5'd10: v = 24'd3667;
            5'd11: v = 24'd1833;
            5'd12: v = 24'd917;
            5'd13: v = 24'd458;
            5'd14: v = 24'd229;
            5'd15: v = 24'd115;
            5'd16: v = 24'd57;
            5'd17: v = 24'd29;
            5'd18: v = 24'd14;
            5'd19: v = 24'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/polyline_position_interpolator.sv]
// Polyline position interpolator top level: sequencer, vertex and length
// memories, shared multiplier. Depends on ppi_pkg, ppi_sqrt, ppi_div, ppi_cordic.
// A query's time is set mostly by the per-segment square root (one bit a
// cycle) and the three passes through the one divider. One query is in
// flight at a time.
// Reset: synchronous, active low; point_count returns to 2, vertices keep
// whatever they held and are undefined until written.
module polyline_position_interpolator import ppi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration: point_count
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [PC_W-1:0]       i_cfg_data,
    // input words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // vertex_index[5:0], vertex_x[21:6], vertex_y[37:22], position[69:38]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind[0]
    input  logic                  s_axis_tuser,
    // result words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // x_pos[23:0], y_pos[47:24], heading_deg[56:48], segment_index[62:57],
    // segment_offset[79:63]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // length_error[0]
    output logic                  m_axis_tuser
);
    t_state r_state, n_state;

    // configuration register
    logic [PC_W-1:0] r_pc;

    // vertex and segment length memories
    logic signed [COORD_W-1:0] x_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] y_mem [MAX_POINTS];
    logic [LEN_W-1:0]          len_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] r_mx0, r_mx1, r_my0, r_my1;
    logic [LEN_W-1:0]          r_lrd;
    logic [IDX_W-1:0]          rd_addr;

    // query working registers
    logic [IDX_W-1:0]          r_k, r_segs, r_seg;
    logic [POS_W-1:0]          r_qpos;
    logic [TOT_W-1:0]          r_total, r_pos, r_cum;
    logic [LEN_W-1:0]          r_len, r_off;
    logic signed [COORD_W-1:0] r_xa, r_xb, r_ya, r_yb;
    logic signed [PROD_W-1:0]  r_prod;
    logic [SQ_W-1:0]           r_sq;
    logic signed [DIFF_W-1:0]  r_dy;
    logic signed [NUM_W-1:0]   r_num;
    logic signed [XPOS_W-1:0]  r_xpos, r_ypos;
    logic signed [DEG_W-1:0]   r_hd;
    logic                      r_err;

    // output register
    logic                  r_mvalid, r_muser;
    logic [OUT_DATA_W-1:0] r_mdata;

    // shared multiplier and unit controls
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     sq_start, sq_done, dv_start, dv_done, hd_start, hd_done;
    logic [LEN_W-1:0]         sq_root;
    logic [DIV_W-1:0]         dv_dividend, dv_quot;
    logic [TOT_W-1:0]         dv_divisor, dv_rem;
    logic signed [DEG_W-1:0]  hd_deg;
    logic                     accept, last_seg, hit, out_free;
    logic [IDX_W:0]           used_pts;
    logic [NUM_W-1:0]         num_mag;
    logic signed [XPOS_W:0]   q_signed;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign last_seg = (r_k == r_segs - 1'b1);
    assign hit      = {1'b0, r_pos} < ({1'b0, r_cum} + (TOT_W + 1)'(r_lrd));
    assign out_free = !r_mvalid || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    // clamp point_count to 2..MAX_POINTS
    always_comb begin
        used_pts = (IDX_W + 1)'(r_pc);
        if (r_pc < PC_W'(2))
            used_pts = (IDX_W + 1)'(2);
        if (r_pc > PC_W'(MAX_POINTS))
            used_pts = (IDX_W + 1)'(MAX_POINTS);
    end

    // magnitude of the interpolation numerator, and the signed quotient
    assign num_mag  = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign q_signed = r_num[NUM_W-1] ? -$signed({1'b0, dv_quot[XPOS_W-1:0]})
                                     : $signed({1'b0, dv_quot[XPOS_W-1:0]});

    assign prod = mul_a * mul_b;

    ppi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_sq),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    ppi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (dv_start),
        .i_dividend (dv_dividend),
        .i_divisor  (dv_divisor),
        .o_done     (dv_done),
        .o_quot     (dv_quot),
        .o_rem      (dv_rem)
    );

    ppi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hd_start),
        .i_num   (DIFF_W'(r_xa) - DIFF_W'(r_xb)),
        .i_den   (DIFF_W'(r_ya) - DIFF_W'(r_yb)),
        .o_done  (hd_done),
        .o_deg   (hd_deg)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (accept && s_axis_tuser) n_state = ST_L_RD;
            ST_L_RD:     n_state = ST_L_MX;
            ST_L_MX:     n_state = ST_L_MY;
            ST_L_MY:     n_state = ST_L_SQ;
            ST_L_SQ:     n_state = ST_L_WAIT;
            ST_L_WAIT:   if (sq_done) n_state = last_seg ? ST_CHK : ST_L_RD;
            ST_CHK:      n_state = (r_total == '0) ? ST_DONE : ST_MOD;
            ST_MOD:      n_state = ST_MOD_WAIT;
            ST_MOD_WAIT: if (dv_done) n_state = ST_W_RD;
            ST_W_RD:     n_state = ST_W_CMP;
            ST_W_CMP:    n_state = hit ? ST_V_RD : ST_W_RD;
            ST_V_RD:     n_state = ST_V_LD;
            ST_V_LD:     n_state = ST_X_M1;
            ST_X_M1:     n_state = ST_X_M2;
            ST_X_M2:     n_state = ST_X_DIV;
            ST_X_DIV:    n_state = ST_X_WAIT;
            ST_X_WAIT:   if (dv_done) n_state = ST_Y_M1;
            ST_Y_M1:     n_state = ST_Y_M2;
            ST_Y_M2:     n_state = ST_Y_DIV;
            ST_Y_DIV:    n_state = ST_Y_WAIT;
            ST_Y_WAIT:   if (dv_done) n_state = ST_HD;
            ST_HD:       n_state = ST_HD_WAIT;
            ST_HD_WAIT:  if (hd_done) n_state = ST_DONE;
            ST_DONE:     if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // controls: memory address, multiplier operands, unit starts
    always_comb begin
        s_axis_tready = 1'b0;
        rd_addr       = r_k;
        mul_a         = '0;
        mul_b         = '0;
        sq_start      = 1'b0;
        dv_start      = 1'b0;
        hd_start      = 1'b0;
        dv_dividend   = DIV_W'(num_mag) << 8;
        dv_divisor    = TOT_W'(r_len);
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_L_MX: begin
                mul_a = MUL_W'(DIFF_W'(r_mx0) - DIFF_W'(r_mx1));
                mul_b = mul_a;
            end
            ST_L_MY: begin
                mul_a = MUL_W'(r_dy);
                mul_b = MUL_W'(r_dy);
            end
            ST_L_SQ: sq_start = 1'b1;
            ST_MOD: begin
                dv_start    = 1'b1;
                dv_dividend = DIV_W'(r_qpos);
                dv_divisor  = r_total;
            end
            ST_V_RD: rd_addr = r_seg;
            ST_X_M1: begin
                mul_a = MUL_W'(r_xa);
                mul_b = $signed(MUL_W'(r_len));
            end
            ST_X_M2: begin
                mul_a = MUL_W'(DIFF_W'(r_xb) - DIFF_W'(r_xa));
                mul_b = $signed(MUL_W'(r_off));
            end
            ST_Y_M1: begin
                mul_a = MUL_W'(r_ya);
                mul_b = $signed(MUL_W'(r_len));
            end
            ST_Y_M2: begin
                mul_a = MUL_W'(DIFF_W'(r_yb) - DIFF_W'(r_ya));
                mul_b = $signed(MUL_W'(r_off));
            end
            ST_X_DIV, ST_Y_DIV: dv_start = 1'b1;
            ST_HD: hd_start = 1'b1;
            default: ;
        endcase
    end

    // memories: write vertices on a write word, lengths as the sum pass finds them
    always_ff @(posedge i_clk) begin
        if (accept && !s_axis_tuser) begin
            x_mem[s_axis_tdata[5:0]] <= s_axis_tdata[21:6];
            y_mem[s_axis_tdata[5:0]] <= s_axis_tdata[37:22];
        end
        if (r_state == ST_L_WAIT && sq_done)
            len_mem[r_k] <= sq_root;
        r_mx0 <= x_mem[rd_addr];
        r_mx1 <= x_mem[rd_addr + 1'b1];
        r_my0 <= y_mem[rd_addr];
        r_my1 <= y_mem[rd_addr + 1'b1];
        r_lrd <= len_mem[r_k];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= PC_W'(2);
            r_mvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid)
                r_pc <= i_cfg_data;
            if (r_state == ST_DONE && out_free)
                r_mvalid <= 1'b1;
            else if (m_axis_tready)
                r_mvalid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_k     <= '0;
                r_total <= '0;
                r_err   <= 1'b0;
                r_qpos  <= s_axis_tdata[69:38];
                r_segs  <= IDX_W'(used_pts - 1'b1);
            end
            ST_L_MX: begin
                r_prod <= prod;
                r_dy   <= DIFF_W'(r_my0) - DIFF_W'(r_my1);
            end
            ST_L_MY: r_sq <= SQ_W'(r_prod) + SQ_W'(prod);
            ST_L_WAIT: if (sq_done) begin
                r_total <= r_total + TOT_W'(sq_root);
                r_k     <= r_k + 1'b1;
            end
            ST_CHK: begin
                r_err <= (r_total == '0);
                r_k   <= '0;
                r_cum <= '0;
            end
            ST_MOD_WAIT: if (dv_done) r_pos <= dv_rem;
            ST_W_CMP: begin
                if (hit) begin
                    r_seg <= r_k;
                    r_len <= r_lrd;
                    r_off <= LEN_W'(r_pos - r_cum);
                end else begin
                    r_cum <= r_cum + TOT_W'(r_lrd);
                    r_k   <= r_k + 1'b1;
                end
            end
            ST_V_LD: begin
                r_xa <= r_mx0;
                r_xb <= r_mx1;
                r_ya <= r_my0;
                r_yb <= r_my1;
            end
            ST_X_M1, ST_Y_M1: r_prod <= prod;
            ST_X_M2, ST_Y_M2: r_num <= NUM_W'(r_prod) + NUM_W'(prod);
            ST_X_WAIT: if (dv_done) r_xpos <= XPOS_W'(q_signed);
            ST_Y_WAIT: if (dv_done) r_ypos <= XPOS_W'(q_signed);
            ST_HD_WAIT: if (hd_done) r_hd <= hd_deg;
            default: ;
        endcase
    end

    // output register: load the result word, zeros with the flag on error
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_muser <= r_err;
            if (r_err)
                r_mdata <= '0;
            else
                r_mdata <= {r_off, r_seg, r_hd, r_ypos, r_xpos};
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;

    // the walk never runs past the last segment
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_W_CMP) |-> (r_k < r_segs))
        else $error("segment walk ran past the last segment");

    // the last segment always contains the reduced position
    a_walk_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_W_CMP && last_seg) |-> hit)
        else $error("reduced position outside the polyline");

    // the walk only starts on a non-zero total, with a reduced position below it
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_W_RD) |-> (r_total != '0 && r_pos < r_total))
        else $error("position not reduced below the total length");

    // an error word carries all-zero data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("error word with non-zero data");
endmodule

[hdl/ppi_sqrt.sv]
// Bit-pair integer square root, one result bit per cycle.
// Depends on ppi_pkg.
module ppi_sqrt import ppi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_W-1:0]  i_value,
    output logic             o_done,
    output logic [LEN_W-1:0] o_root
);
    logic            r_busy, r_done;
    logic [SQ_W-1:0] r_v, r_r, r_bit;
    logic [SQ_W:0]   sum;
    logic            ge;

    assign sum    = {1'b0, r_r} + {1'b0, r_bit};
    assign ge     = {1'b0, r_v} >= sum;
    assign o_done = r_done;
    assign o_root = r_r[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == SQ_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (r_busy) begin
            if (ge) begin
                r_v <= r_v - sum[SQ_W-1:0];
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end
endmodule

[hdl/ppi_div.sv]
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// Depends on ppi_pkg.
module ppi_div import ppi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [TOT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot,
    output logic [TOT_W-1:0] o_rem
);
    logic              r_busy, r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_q;
    logic [TOT_W-1:0]  r_rem, r_d;
    logic [TOT_W:0]    trial, diff;
    logic              ge;

    assign trial  = {r_rem, r_q[DIV_W-1]};
    assign ge     = trial >= {1'b0, r_d};
    assign diff   = trial - {1'b0, r_d};
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], ge};
        end
    end
endmodule

[hdl/ppi_cordic.sv]
// Vectoring CORDIC heading unit, one rotation per cycle, result in degrees.
// Depends on ppi_pkg.
module ppi_cordic import ppi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIFF_W-1:0] i_num,
    input  logic signed [DIFF_W-1:0] i_den,
    output logic                     o_done,
    output logic signed [DEG_W-1:0]  o_deg
);
    localparam logic signed [Z_W-1:0] ZMAX = Z_W'(90 * 65536);

    logic                    r_busy, r_done;
    logic [CI_W-1:0]         r_i;
    logic                    r_nneg, r_dneg;
    logic [DIFF_W-1:0]       r_ax, r_ay;
    logic signed [CXY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]   r_z;
    logic signed [CXY_W-1:0] xs, ys, ny;
    logic [DIFF_W-1:0]       ax, ay;
    logic signed [Z_W-1:0]   zc, zr;
    logic [7:0]              fl, ce, mag;

    assign ax = i_den[DIFF_W-1] ? DIFF_W'(-i_den) : i_den;
    assign ay = i_num[DIFF_W-1] ? DIFF_W'(-i_num) : i_num;
    assign ny = -r_y;
    assign xs = r_x >>> r_i;
    assign ys = r_y[CXY_W-1] ? -(ny >>> r_i) : (r_y >>> r_i);

    always_comb begin
        zc = r_z;
        if (r_z < 0)
            zc = '0;
        if (r_z > ZMAX)
            zc = ZMAX;
        zr = zc + Z_W'(65535);
        priority if (r_ay == '0) begin
            fl = 8'd0;
            ce = 8'd0;
        end else if (r_ax == '0) begin
            fl = 8'd90;
            ce = 8'd90;
        end else if (r_ax == r_ay) begin
            fl = 8'd45;
            ce = 8'd45;
        end else begin
            fl = 8'(zc[Z_W-1:16]);
            ce = 8'(zr[Z_W-1:16]);
        end
        mag   = r_dneg ? 8'(8'd180 - ce) : fl;
        o_deg = r_nneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_i == CI_W'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i    <= '0;
            r_nneg <= i_num[DIFF_W-1];
            r_dneg <= i_den[DIFF_W-1];
            r_ax   <= ax;
            r_ay   <= ay;
            r_x    <= $signed(CXY_W'(ax) << 8);
            r_y    <= $signed(CXY_W'(ay) << 8);
            r_z    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + $signed(atan_deg(r_i));
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - $signed(atan_deg(r_i));
            end
        end
    end
endmodule

[tb/testbench.sv]
// Testbench for polyline_position_interpolator: drives vertex writes and
// position queries and checks every result word against its own predictor.
// Depends on ppi_pkg and the RTL of the block; needs no other file.
module testbench;
    import ppi_pkg::*;

    localparam int  CLK_LIMIT = 4000000;
    localparam int  HOLD_LEN  = 800;
    localparam bit  KIND_WRITE = 1'b0;
    localparam bit  KIND_QUERY = 1'b1;

    typedef struct {
        bit                 kind;
        bit [5:0]           vidx;
        bit signed [15:0]   vx;
        bit signed [15:0]   vy;
        bit [31:0]          pos;
    } t_poly_word;

    typedef struct {
        bit signed [23:0]   xpos;
        bit signed [23:0]   ypos;
        bit signed [8:0]    hdg;
        bit [5:0]           seg;
        bit [16:0]          off;
        bit                 lerr;
    } t_point;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [PC_W-1:0]       i_cfg_data;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    polyline_position_interpolator dut (.*);

    // Predictor state: vertex stores and the point count register
    bit signed [15:0] vert_x [64];
    bit signed [15:0] vert_y [64];
    bit [6:0]         point_cnt;

    t_poly_word pending_words[$];
    t_point     expected_points[$];
    t_poly_word cur_word;
    bit         word_taken;
    int         words_pushed, words_taken, points_checked, errors, queries_seen;
    int         cycles;
    int         send_idle_pct, recv_idle_pct;
    bit         hold_req, hold_seen;
    int         hold_left;

    // Integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned seg_length(int k);
        longint dx = longint'(vert_x[k]) - longint'(vert_x[k+1]);
        longint dy = longint'(vert_y[k]) - longint'(vert_y[k+1]);
        return int_sqrt(unsigned'(dx * dx) + unsigned'(dy * dy));
    endfunction

    function automatic longint shift_tz(longint v, int i);
        if (v < 0) return -(longint'(unsigned'(-v) >> i));
        return longint'(unsigned'(v) >> i);
    endfunction

    // atan2(num, den) in whole degrees, truncated toward zero
    function automatic longint heading_of(longint num, longint den);
        longint ay = num < 0 ? -num : num;
        longint ax = den < 0 ? -den : den;
        longint fl, ce, mag, x, y, z, xs, ys;
        longint atan_tab [20] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                  58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                  229, 115, 57, 29, 14, 7};
        if (ay == 0) begin
            fl = 0; ce = 0;
        end else if (ax == 0) begin
            fl = 90; ce = 90;
        end else if (ax == ay) begin
            fl = 45; ce = 45;
        end else begin
            x = ax * 256; y = ay * 256; z = 0;
            for (int i = 0; i < 20; i++) begin
                xs = shift_tz(x, i);
                ys = shift_tz(y, i);
                if (y > 0) begin
                    x += ys; y -= xs; z += atan_tab[i];
                end else begin
                    x -= ys; y += xs; z -= atan_tab[i];
                end
            end
            if (z < 0) z = 0;
            if (z > 90 * 65536) z = 90 * 65536;
            fl = z >>> 16;
            ce = (z + 65535) >>> 16;
        end
        mag = (den < 0) ? 180 - ce : fl;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint lerp_q8(longint a, longint b, longint off, longint len);
        return (a * 256 * len + (b - a) * off * 256) / len;
    endfunction

    function automatic int used_points();
        if (point_cnt < 2) return 2;
        if (point_cnt > 64) return 64;
        return point_cnt;
    endfunction

    // Locate the position on the polyline and interpolate
    function automatic t_point locate_point(bit [31:0] pos_in);
        t_point p = '{default: 0};
        int n = used_points();
        int seg = 0;
        longint unsigned total = 0, pos, cum = 0, len = 0;
        for (int k = 0; k + 1 < n; k++) total += seg_length(k);
        if (total == 0) begin
            p.lerr = 1;
            return p;
        end
        pos = pos_in % total;
        for (int k = 0; k + 1 < n; k++) begin
            len = seg_length(k);
            if (pos < cum + len) begin
                seg = k;
                break;
            end
            cum += len;
        end
        p.xpos = 24'(lerp_q8(vert_x[seg], vert_x[seg+1], pos - cum, len));
        p.ypos = 24'(lerp_q8(vert_y[seg], vert_y[seg+1], pos - cum, len));
        p.hdg  = 9'(heading_of(longint'(vert_x[seg]) - vert_x[seg+1],
                               longint'(vert_y[seg]) - vert_y[seg+1]));
        p.seg  = 6'(seg);
        p.off  = 17'(pos - cum);
        return p;
    endfunction

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Idle profile advances with the words accepted so far
    always_comb begin
        if (words_taken < 300) begin
            send_idle_pct = 30; recv_idle_pct = 83;
        end else if (words_taken < 600) begin
            send_idle_pct = 83; recv_idle_pct = 30;
        end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
        end
    end

    // Input side: record acceptance and update the predictor at the edge
    always @(posedge i_clk) begin
        word_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            words_taken++;
            if (cur_word.kind == KIND_WRITE) begin
                vert_x[cur_word.vidx] = cur_word.vx;
                vert_y[cur_word.vidx] = cur_word.vy;
            end else begin
                expected_points.push_back(locate_point(cur_word.pos));
                queries_seen++;
            end
        end
    end

    // Driver: hold the word until taken, then advance or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
        end else if (!s_axis_tvalid || word_taken) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_word = pending_words.pop_front();
                s_axis_tvalid <= 1;
                s_axis_tuser  <= cur_word.kind;
                s_axis_tdata  <= {2'b00, cur_word.pos, cur_word.vy, cur_word.vx,
                                  cur_word.vidx};
            end else begin
                s_axis_tvalid <= 0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_point got, exp_pt;
        cycles++;
        if (cycles > CLK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.xpos = m_axis_tdata[23:0];
            got.ypos = m_axis_tdata[47:24];
            got.hdg  = m_axis_tdata[56:48];
            got.seg  = m_axis_tdata[62:57];
            got.off  = m_axis_tdata[79:63];
            got.lerr = m_axis_tuser;
            if (expected_points.size() == 0) begin
                $error("result word with no query pending");
                errors++;
            end else begin
                exp_pt = expected_points.pop_front();
                points_checked++;
                if (got.xpos != exp_pt.xpos) begin
                    $error("x_pos: expected %0d, got %0d", exp_pt.xpos, got.xpos);
                    errors++;
                end
                if (got.ypos != exp_pt.ypos) begin
                    $error("y_pos: expected %0d, got %0d", exp_pt.ypos, got.ypos);
                    errors++;
                end
                if (got.hdg != exp_pt.hdg) begin
                    $error("heading_deg: expected %0d, got %0d", exp_pt.hdg, got.hdg);
                    errors++;
                end
                if (got.seg != exp_pt.seg) begin
                    $error("segment_index: expected %0d, got %0d", exp_pt.seg, got.seg);
                    errors++;
                end
                if (got.off != exp_pt.off) begin
                    $error("segment_offset: expected %0d, got %0d", exp_pt.off, got.off);
                    errors++;
                end
                if (got.lerr != exp_pt.lerr) begin
                    $error("length_error: expected %0d, got %0d", exp_pt.lerr, got.lerr);
                    errors++;
                end
            end
        end
    end

    task automatic push_write(int idx, int x, int y);
        t_poly_word w;
        w.kind = KIND_WRITE; w.vidx = 6'(idx); w.vx = 16'(x); w.vy = 16'(y);
        w.pos = $urandom;
        pending_words.push_back(w);
        words_pushed++;
    endtask

    task automatic push_query(bit [31:0] pos);
        t_poly_word w;
        w.kind = KIND_QUERY; w.vidx = 6'($urandom); w.vx = 16'($urandom);
        w.vy = 16'($urandom);
        w.pos = pos;
        pending_words.push_back(w);
        words_pushed++;
    endtask

    // Wait until every word is taken and every result has come, then let
    // a trailing vertex write settle
    task automatic drain();
        while (words_taken != words_pushed || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_point_count(int v);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data  <= PC_W'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        point_cnt = 7'(v);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // Random traffic: writes land mostly inside the used span, coordinates
    // are often tiny or repeated so exact headings and empty segments show up
    task automatic random_phase(int pc, int count);
        int n, idx, x, y;
        write_point_count(pc);
        n = used_points();
        repeat (count) begin
            if ($urandom_range(0, 99) < 40) begin
                idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, n - 1);
                case ($urandom_range(0, 3))
                    0: begin
                        x = $signed(16'($urandom)); y = $signed(16'($urandom));
                    end
                    1: begin
                        x = vert_x[idx == 0 ? 1 : idx - 1];
                        y = vert_y[idx == 0 ? 1 : idx - 1];
                    end
                    default: begin
                        x = $urandom_range(0, 40) - 20; y = $urandom_range(0, 40) - 20;
                    end
                endcase
                push_write(idx, x, y);
            end else begin
                push_query($urandom_range(0, 1) ? $urandom : $urandom_range(0, 300));
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_data = '0;
        point_cnt = 2;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Load every vertex once so no query reads an unwritten entry
        for (int i = 0; i < 64; i++)
            push_write(i, $urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100);
        drain();

        // Directed: zero total length, coordinate extremes, exact headings
        push_write(0, 0, 0);
        push_write(1, 0, 0);
        push_query(5);
        push_write(0, -32768, 32767);
        push_write(1, 32767, -32768);
        push_query(0);
        push_query(32'hFFFF_FFFF);
        push_query(12345);
        push_write(0, 0, 0);
        push_write(1, 0, 100);
        push_query(50);
        push_write(1, 0, -100);
        push_query(99);
        push_write(1, 100, 0);
        push_query(1);
        push_write(1, -100, -100);
        push_query(77);
        push_write(1, -100, 100);
        push_query(140);
        push_write(1, 30, -70);
        push_query(32'h8000_0000);
        drain();
        write_point_count(3);
        push_write(1, 0, 0);
        push_write(2, 40, 30);
        push_query(10);
        push_query(49);
        drain();

        random_phase(2, 60);
        random_phase(0, 40);
        random_phase(1, 40);
        random_phase(3, 80);
        // Long receiver hold-off while the sender keeps offering words
        hold_req = ~hold_req;
        random_phase(5, 100);
        random_phase(8, 120);
        random_phase(127, 25);
        random_phase(4, 80);
        random_phase(64, 20);
        random_phase(6, 80);
        random_phase(100, 15);
        random_phase(2, 60);

        $display("Covered %0d words, %0d queries, %0d results checked, point counts 0..127.",
                 words_taken, queries_seen, points_checked);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
